FILE: design/sil_pkg.sv
// Shared types and constants for the serial image loader.
`default_nettype none

package sil_pkg;

  // Header framing.
  localparam logic [7:0] MAGIC_BYTE = 8'h23;
  localparam int unsigned MAGIC_RUN = 4;
  localparam int unsigned MAGIC_CNT_W = $clog2(MAGIC_RUN);

  // Widths of the result fields.
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_LAST  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // One result transaction as it leaves the loader core.
  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [BYTE_W-1:0]  data;
    logic [ADDR_W-1:0]  entry_address;
  } sil_result_t;

endpackage

`default_nettype wire

FILE: design/sil_core.sv
// Header parser and write generator of the serial image loader.
`default_nettype none

module sil_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [sil_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [sil_pkg::ADDR_W-1:0] protect_start,
  input  wire logic [sil_pkg::ADDR_W-1:0] protect_end,
  output logic                            res_valid,
  output sil_pkg::sil_result_t            res
);
  import sil_pkg::*;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_ADDR   = 6'b000010,
    PH_LEN    = 6'b000100,
    PH_ENTRY  = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_LOCKED = 6'b100000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [MAGIC_CNT_W-1:0] magic_cnt_r, magic_cnt_nxt;
  logic [1:0]             byte_idx_r, byte_idx_nxt;
  logic [ADDR_W-1:0]      word_shift_r, word_shift_nxt;
  logic [ADDR_W-1:0]      write_addr_r, write_addr_nxt;
  logic [ADDR_W-1:0]      bytes_left_r, bytes_left_nxt;
  logic [ADDR_W-1:0]      entry_r, entry_nxt;

  logic [ADDR_W-1:0]      word_full;
  logic [ADDR_W-1:0]      image_end;
  logic                   overlap;

  // Merge the incoming byte into the header word, least significant byte first.
  always_comb begin
    word_full = word_shift_r;
    case (byte_idx_r)
      2'd0:    word_full[7:0]   = rx_byte;
      2'd1:    word_full[15:8]  = rx_byte;
      2'd2:    word_full[23:16] = rx_byte;
      default: word_full[31:24] = rx_byte;
    endcase
  end

  // The image overlaps when its start or its wrapped end falls in the protected window.
  assign image_end = write_addr_r + bytes_left_r;
  assign overlap   = ((write_addr_r >= protect_start) && (write_addr_r < protect_end)) ||
                     ((image_end >= protect_start) && (image_end < protect_end));

  // Next state and result for one byte.
  always_comb begin
    phase_nxt      = phase_r;
    magic_cnt_nxt  = magic_cnt_r;
    byte_idx_nxt   = byte_idx_r;
    word_shift_nxt = word_shift_r;
    write_addr_nxt = write_addr_r;
    bytes_left_nxt = bytes_left_r;
    entry_nxt      = entry_r;
    res_valid      = 1'b0;
    res            = '0;

    if (step) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == MAGIC_BYTE) begin
            if (magic_cnt_r == MAGIC_CNT_W'(MAGIC_RUN - 1)) begin
              magic_cnt_nxt  = '0;
              byte_idx_nxt   = '0;
              word_shift_nxt = '0;
              phase_nxt      = PH_ADDR;
            end else begin
              magic_cnt_nxt = magic_cnt_r + 1'b1;
            end
          end else begin
            magic_cnt_nxt = '0;
          end
        end

        PH_ADDR, PH_LEN, PH_ENTRY: begin
          if (byte_idx_r != 2'd3) begin
            word_shift_nxt = word_full;
            byte_idx_nxt   = byte_idx_r + 1'b1;
          end else begin
            byte_idx_nxt   = '0;
            word_shift_nxt = '0;
            if (phase_r == PH_ADDR) begin
              write_addr_nxt = word_full;
              phase_nxt      = PH_LEN;
            end else if (phase_r == PH_LEN) begin
              bytes_left_nxt = word_full;
              phase_nxt      = PH_ENTRY;
            end else begin
              entry_nxt = word_full;
              if (overlap) begin
                phase_nxt         = PH_LOCKED;
                res_valid         = 1'b1;
                res.kind          = KIND_ERROR;
                res.address       = write_addr_r;
                res.entry_address = word_full;
              end else if (bytes_left_r == '0) begin
                phase_nxt         = PH_HUNT;
                res_valid         = 1'b1;
                res.kind          = KIND_EMPTY;
                res.address       = write_addr_r;
                res.entry_address = word_full;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
        end

        PH_DATA: begin
          bytes_left_nxt = bytes_left_r - 1'b1;
          write_addr_nxt = write_addr_r + 1'b1;
          res_valid      = 1'b1;
          res.address    = write_addr_r;
          res.data       = rx_byte;
          if (bytes_left_r == ADDR_W'(1)) begin
            res.kind          = KIND_LAST;
            res.entry_address = entry_r;
            phase_nxt         = PH_HUNT;
          end else begin
            res.kind = KIND_WRITE;
          end
        end

        PH_LOCKED: begin
          // Stays locked until reset; bytes are dropped.
        end

        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      magic_cnt_r <= '0;
      byte_idx_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      magic_cnt_r <= magic_cnt_nxt;
      byte_idx_r  <= byte_idx_nxt;
    end
  end

  // Header words and the running write state.
  always_ff @(posedge clk) begin
    word_shift_r <= word_shift_nxt;
    write_addr_r <= write_addr_nxt;
    bytes_left_r <= bytes_left_nxt;
    entry_r      <= entry_nxt;
  end

endmodule

`default_nettype wire

FILE: design/serial_image_loader.sv
// Top level of the serial image loader: stream ports, configuration and output register.
//
// Usage: received serial bytes enter one per transaction on the in_ channel
// (in_tdata). The loader hunts for four 0x23 bytes, then reads the load
// address, length and entry point (least significant byte first), and turns
// each following byte into a write transaction on the out_ channel.
// out_tuser carries the kind: write, last write, empty image or overlap error.
// The protected region is set through the cfg_ port (index 0: start,
// index 1: end); the user must set it only while the loader is idle,
// which the block itself does not enforce; cfg_ready is always high.
// out_tvalid rises after the byte sits in the input register and the
// parser fills the output register. Throughput: one byte per cycle while
// out_tready is high; the parser updates its state once per byte.
// Reset (rst_n low, synchronous) returns the loader to hunting, clears an
// overlap lock and sets the protected region to empty.
// When the receiver stalls, the result waits in the output register and one
// more byte is held in the input register; in_tready then drops.
`default_nettype none

module serial_image_loader (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream: [7:0] rx_byte.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // Result stream: [31:0] address, [39:32] data, [71:40] entry_address.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,
  // Result kind: [1:0] kind.
  output logic [1:0]       out_tuser,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import sil_pkg::*;

  localparam logic [7:0] CFG_PROTECT_START = 8'd0;
  localparam logic [7:0] CFG_PROTECT_END   = 8'd1;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r;
  sil_result_t       out_res_r;
  logic [ADDR_W-1:0] protect_start_r;
  logic [ADDR_W-1:0] protect_end_r;

  logic              advance;
  logic              res_valid;
  sil_result_t       res;

  // The held byte moves into the parser when the output register can take a result.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protect_start_r <= '0;
      protect_end_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROTECT_START: protect_start_r <= cfg_data;
        CFG_PROTECT_END:   protect_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  sil_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .rx_byte       (in_byte_r),
    .protect_start (protect_start_r),
    .protect_end   (protect_end_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {out_res_r.entry_address, out_res_r.data, out_res_r.address};

endmodule

`default_nettype wire
